>>> sv/lifeg_pkg.sv
package lifeg_pkg;

   localparam int GRID_COLS = 64;
   localparam int GRID_ROWS = 32;

   localparam int COL_W = $clog2(GRID_COLS);
   localparam int ROW_W = $clog2(GRID_ROWS);
   // The generation sweep counter runs from 0 to GRID_ROWS + 1.
   localparam int CNT_W = $clog2(GRID_ROWS + 2);

   localparam int CMD_W   = 2;
   localparam int CCOL_W  = 6;
   localparam int CROW_W  = 5;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 8;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   typedef logic [GRID_COLS-1:0] row_type;

   // Controller to datapath.
   typedef struct packed {
      logic             load_req;
      logic             cell_rd;
      logic             cell_op;
      logic             step_rd;
      logic [ROW_W-1:0] step_rd_row;
      logic             step_clear;
      logic             step_shift;
      logic             step_wr;
      logic [ROW_W-1:0] step_wr_row;
      logic             next_zero;
      logic             load_rsp;
   } ctrl_type;

   // Datapath to controller, decoded from the incoming request.
   typedef struct packed {
      logic is_cell;
      logic is_step;
   } status_type;

endpackage

>>> sv/life_cellular_automaton_grid_core.sv
// Cell write or read: after the accept the controller reads the grid row, then writes or
// samples the cell, then loads the response in the finish state once the response slot is
// free. Generation step: the controller sweeps the rows, one row per cycle through the
// single read and single write port of the grid, then finishes the same way.
// One request is in flight at a time; a new request is taken while a response waits.
// Reset is synchronous, active high; it clears the controller and marks every grid row dead.
module life_cellular_automaton_grid_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [1:0] cmd, [7:2] cell_col, [12:8] cell_row, [13] alive_in, [15:14] zero
   input  logic [lifeg_pkg::REQ_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] cell_value, [7:1] zero
   output logic [lifeg_pkg::RSP_W-1:0] rsp_tdata
);

   lifeg_pkg::ctrl_type   ctrl;
   lifeg_pkg::status_type status;

   lifeg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   lifeg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .ctrl      (ctrl),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> sv/lifeg_datapath.sv
module lifeg_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lifeg_pkg::REQ_W-1:0] req_tdata,
   input  lifeg_pkg::ctrl_type         ctrl,
   output lifeg_pkg::status_type       status,
   output logic [lifeg_pkg::RSP_W-1:0] rsp_tdata
);

   logic [lifeg_pkg::CMD_W-1:0]  req_cmd;
   logic [lifeg_pkg::CCOL_W-1:0] req_col;
   logic [lifeg_pkg::CROW_W-1:0] req_row;
   logic                         req_alive;
   logic                         in_grid;

   logic                         is_write_ff, is_write_in;
   logic [lifeg_pkg::COL_W-1:0]  col_ff, col_in;
   logic [lifeg_pkg::ROW_W-1:0]  row_ff, row_in;
   logic                         alive_ff, alive_in;
   logic                         val_ff, val_in;
   logic                         rsp_data_ff, rsp_data_in;

   lifeg_pkg::row_type           mem_ff [lifeg_pkg::GRID_ROWS];
   logic [lifeg_pkg::GRID_ROWS-1:0] vld_ff;
   lifeg_pkg::row_type           rdata_ff;
   lifeg_pkg::row_type           prev_ff, prev_in;
   lifeg_pkg::row_type           cur_ff, cur_in;
   lifeg_pkg::row_type           next_row;
   lifeg_pkg::row_type           merged_row;
   lifeg_pkg::row_type           life_row;
   lifeg_pkg::row_type           wdata;
   logic                         rd_en;
   logic [lifeg_pkg::ROW_W-1:0]  raddr;
   logic                         wr_en;
   logic [lifeg_pkg::ROW_W-1:0]  waddr;

   // One generation of a row from the rows above and below; cells past
   // either edge are dead.
   function automatic lifeg_pkg::row_type life_next(
      input lifeg_pkg::row_type above,
      input lifeg_pkg::row_type mid,
      input lifeg_pkg::row_type below
   );
      logic [lifeg_pkg::GRID_COLS+1:0] pa;
      logic [lifeg_pkg::GRID_COLS+1:0] pm;
      logic [lifeg_pkg::GRID_COLS+1:0] pb;
      logic [3:0]                      n;
      lifeg_pkg::row_type              r;
      int                              i;
      pa = {1'b0, above, 1'b0};
      pm = {1'b0, mid, 1'b0};
      pb = {1'b0, below, 1'b0};
      r  = '0;
      for (i = 0; i < lifeg_pkg::GRID_COLS; i++) begin
         n = 4'(pa[i]) + 4'(pa[i+1]) + 4'(pa[i+2]) + 4'(pm[i]) + 4'(pm[i+2])
           + 4'(pb[i]) + 4'(pb[i+1]) + 4'(pb[i+2]);
         r[i] = (n == lifeg_pkg::BIRTH_COUNT) || (mid[i] && (n == lifeg_pkg::SURVIVE_COUNT));
      end
      return r;
   endfunction

   assign req_cmd   = req_tdata[1:0];
   assign req_col   = req_tdata[7:2];
   assign req_row   = req_tdata[12:8];
   assign req_alive = req_tdata[13];

   assign in_grid = (32'(req_col) < lifeg_pkg::GRID_COLS) &&
                    (32'(req_row) < lifeg_pkg::GRID_ROWS);

   always_comb begin
      status.is_cell = ((req_cmd == lifeg_pkg::CMD_WRITE) || (req_cmd == lifeg_pkg::CMD_READ))
                       && in_grid;
      status.is_step = (req_cmd == lifeg_pkg::CMD_STEP);
   end

   always_comb begin
      is_write_in = is_write_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      alive_in    = alive_ff;
      if (ctrl.load_req) begin
         is_write_in = (req_cmd == lifeg_pkg::CMD_WRITE);
         col_in      = req_col[lifeg_pkg::COL_W-1:0];
         row_in      = lifeg_pkg::ROW_W'(req_row);
         alive_in    = req_alive;
      end
   end

   always_comb begin
      val_in = val_ff;
      if (ctrl.load_req) begin
         val_in = 1'b0;
      end else if (ctrl.cell_op && !is_write_ff) begin
         val_in = rdata_ff[col_ff];
      end
   end

   assign rsp_data_in = ctrl.load_rsp ? val_ff : rsp_data_ff;
   assign rsp_tdata   = {{(lifeg_pkg::RSP_W-1){1'b0}}, rsp_data_ff};

   // Rows above and below the current one in the old generation.
   assign next_row = ctrl.next_zero ? '0 : rdata_ff;
   assign life_row = life_next(prev_ff, cur_ff, next_row);

   always_comb begin
      prev_in = prev_ff;
      cur_in  = cur_ff;
      if (ctrl.step_clear) begin
         prev_in = '0;
         cur_in  = '0;
      end else if (ctrl.step_shift) begin
         prev_in = cur_ff;
         cur_in  = next_row;
      end
   end

   always_comb begin
      merged_row         = rdata_ff;
      merged_row[col_ff] = alive_ff;
   end

   assign rd_en = ctrl.cell_rd || ctrl.step_rd;
   assign raddr = ctrl.step_rd ? ctrl.step_rd_row : row_ff;
   assign wr_en = ctrl.step_wr || (ctrl.cell_op && is_write_ff);
   assign waddr = ctrl.step_wr ? ctrl.step_wr_row : row_ff;
   assign wdata = ctrl.step_wr ? life_row : merged_row;

   always_ff @(posedge clock) begin
      is_write_ff <= is_write_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      alive_ff    <= alive_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
   end

   // Grid storage; a row that was never written since reset reads as dead.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= vld_ff[raddr] ? mem_ff[raddr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[waddr] <= 1'b1;
      end
   end

endmodule

>>> sv/lifeg_ctrl.sv
module lifeg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  lifeg_pkg::status_type status,
   output lifeg_pkg::ctrl_type   ctrl
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CELL_RD = 3'd1;
   localparam logic [2:0] S_CELL_OP = 3'd2;
   localparam logic [2:0] S_STEP    = 3'd3;
   localparam logic [2:0] S_FINISH  = 3'd4;

   localparam logic [lifeg_pkg::CNT_W-1:0] CNT_LAST = lifeg_pkg::CNT_W'(lifeg_pkg::GRID_ROWS + 1);
   localparam logic [lifeg_pkg::CNT_W-1:0] CNT_ROWS = lifeg_pkg::CNT_W'(lifeg_pkg::GRID_ROWS);
   localparam logic [lifeg_pkg::CNT_W-1:0] CNT_TWO  = lifeg_pkg::CNT_W'(2);

   logic [2:0]                    state_ff, state_in;
   logic [lifeg_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          accept;
   logic                          rsp_free;
   logic [lifeg_pkg::CNT_W-1:0]   wr_cnt;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign wr_cnt     = cnt_ff - CNT_TWO;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctrl     = '0;
      ctrl.step_rd_row = cnt_ff[lifeg_pkg::ROW_W-1:0];
      ctrl.step_wr_row = wr_cnt[lifeg_pkg::ROW_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ctrl.load_req = 1'b1;
               cnt_in        = '0;
               priority if (status.is_cell) begin
                  state_in = S_CELL_RD;
               end else if (status.is_step) begin
                  state_in = S_STEP;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_CELL_RD: begin
            ctrl.cell_rd = 1'b1;
            state_in     = S_CELL_OP;
         end
         S_CELL_OP: begin
            ctrl.cell_op = 1'b1;
            state_in     = S_FINISH;
         end
         S_STEP: begin
            // Read row k, and at the same time write the new row k-2 from
            // the two rows held and the row that just came back.
            ctrl.step_rd    = (cnt_ff < CNT_ROWS);
            ctrl.step_clear = (cnt_ff == '0);
            ctrl.step_shift = (cnt_ff != '0);
            ctrl.step_wr    = (cnt_ff >= CNT_TWO);
            ctrl.next_zero  = (cnt_ff == CNT_LAST);
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               ctrl.load_rsp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("request accepted but controller stayed idle");

   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (cnt_ff <= CNT_LAST))
      else $error("generation counter ran past the last row");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!ctrl.step_wr && !ctrl.cell_op))
      else $error("grid write issued while idle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside the finish state");
`endif

endmodule

>>> tb/life_grid_checker.sv
module life_grid_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   // [1:0] cmd, [7:2] cell_col, [12:8] cell_row, [13] alive_in, [15:14] zero
   input  logic [lifeg_pkg::REQ_W-1:0] req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] cell_value, [7:1] zero
   input  logic [lifeg_pkg::RSP_W-1:0] rsp_tdata,
   output int                          fail_count,
   output int                          pending_count,
   output int                          checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]                   pad;
      logic                         alive_in;
      logic [lifeg_pkg::CROW_W-1:0] cell_row;
      logic [lifeg_pkg::CCOL_W-1:0] cell_col;
      logic [lifeg_pkg::CMD_W-1:0]  cmd;
   } grid_request_type;

   lifeg_pkg::row_type life_grid [lifeg_pkg::GRID_ROWS];
   logic               expected_values [$];
   int                 mismatch_total;
   int                 checked_total;

   // Cells outside the grid read as dead.
   function automatic int cell_at(int r, int c);
      if (r < 0 || r >= lifeg_pkg::GRID_ROWS || c < 0 || c >= lifeg_pkg::GRID_COLS)
         return 0;
      return int'(life_grid[r][c]);
   endfunction

   function automatic void advance_generation();
      lifeg_pkg::row_type next_rows [lifeg_pkg::GRID_ROWS];
      int                 neighbors;
      for (int r = 0; r < lifeg_pkg::GRID_ROWS; r++) begin
         next_rows[r] = '0;
         for (int c = 0; c < lifeg_pkg::GRID_COLS; c++) begin
            neighbors = 0;
            for (int dr = -1; dr <= 1; dr++)
               for (int dc = -1; dc <= 1; dc++)
                  if (dr != 0 || dc != 0)
                     neighbors += cell_at(r + dr, c + dc);
            if (cell_at(r, c) != 0)
               next_rows[r][c] = (neighbors == int'(lifeg_pkg::SURVIVE_COUNT)) ||
                                 (neighbors == int'(lifeg_pkg::BIRTH_COUNT));
            else
               next_rows[r][c] = (neighbors == int'(lifeg_pkg::BIRTH_COUNT));
         end
      end
      // Every count above saw the old generation; commit only now.
      for (int r = 0; r < lifeg_pkg::GRID_ROWS; r++)
         life_grid[r] = next_rows[r];
   endfunction

   function automatic logic predict_cell_value(grid_request_type req);
      logic in_grid;
      in_grid = (int'(req.cell_col) < lifeg_pkg::GRID_COLS) &&
                (int'(req.cell_row) < lifeg_pkg::GRID_ROWS);
      case (req.cmd)
         lifeg_pkg::CMD_WRITE: begin
            if (in_grid)
               life_grid[req.cell_row][req.cell_col] = req.alive_in;
            return 1'b0;
         end
         lifeg_pkg::CMD_READ: begin
            return in_grid ? life_grid[req.cell_row][req.cell_col] : 1'b0;
         end
         lifeg_pkg::CMD_STEP: begin
            advance_generation();
            return 1'b0;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   task automatic report_mismatch(string what);
      $display("ERROR %0t: %s", $realtime, what);
      mismatch_total++;
   endtask

   always @(posedge clock) begin
      logic expected;
      if (reset) begin
         for (int r = 0; r < lifeg_pkg::GRID_ROWS; r++)
            life_grid[r] = '0;
         expected_values.delete();
         mismatch_total = 0;
         checked_total = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_values = {expected_values,
                               predict_cell_value(grid_request_type'(req_tdata))};
         if (rsp_tvalid && rsp_tready) begin
            if (expected_values.size() == 0) begin
               report_mismatch($sformatf("response %0h arrived with no request outstanding",
                                         rsp_tdata));
            end else begin
               expected = expected_values.pop_front();
               checked_total++;
               if (rsp_tdata[0] !== expected)
                  report_mismatch($sformatf("response %0d: cell_value %b, expected %b",
                                            checked_total, rsp_tdata[0], expected));
            end
         end
      end
      fail_count    <= mismatch_total;
      pending_count <= expected_values.size();
      checked_count <= checked_total;
   end

endmodule

>>> tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET    = 1150;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam logic [lifeg_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   // [1:0] cmd, [7:2] cell_col, [12:8] cell_row, [13] alive_in, [15:14] zero
   logic [lifeg_pkg::REQ_W-1:0] req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   // [0] cell_value, [7:1] zero
   logic [lifeg_pkg::RSP_W-1:0] rsp_tdata;

   int fail_count;
   int pending_count;
   int checked_count;
   int tx_idle_pct;
   int rx_idle_pct;
   int stall_cycles;
   int sent_total;
   int write_count;
   int read_count;
   int step_count;
   int unused_count;

   life_cellular_automaton_grid_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   life_grid_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     stall_cycles, pending_count);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Present one request, with random gaps in front of it, and hold it until taken.
   task automatic send_request(logic [lifeg_pkg::CMD_W-1:0] cmd,
                               logic [lifeg_pkg::CCOL_W-1:0] col,
                               logic [lifeg_pkg::CROW_W-1:0] row, logic alive);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, alive, row, col, cmd};
      do
         @(posedge clock);
      while (!req_tready);
      sent_total++;
      case (cmd)
         lifeg_pkg::CMD_WRITE: write_count++;
         lifeg_pkg::CMD_READ:  read_count++;
         lifeg_pkg::CMD_STEP:  step_count++;
         default:              unused_count++;
      endcase
   endtask

   // Seed a window, often on an edge or a corner, evolve it and probe around it.
   task automatic run_round();
      int span;
      int base_col;
      int base_row;
      int lo_col;
      int hi_col;
      int lo_row;
      int hi_row;
      span = $urandom_range(10, 4);
      base_col = $urandom_range(lifeg_pkg::GRID_COLS - span);
      base_row = $urandom_range(lifeg_pkg::GRID_ROWS - span);
      case ($urandom_range(3))
         1: base_col = $urandom_range(1) ? 0 : lifeg_pkg::GRID_COLS - span;
         2: base_row = $urandom_range(1) ? 0 : lifeg_pkg::GRID_ROWS - span;
         3: begin
            base_col = $urandom_range(1) ? 0 : lifeg_pkg::GRID_COLS - span;
            base_row = $urandom_range(1) ? 0 : lifeg_pkg::GRID_ROWS - span;
         end
         default: ;
      endcase
      lo_col = (base_col > 0) ? base_col - 1 : 0;
      lo_row = (base_row > 0) ? base_row - 1 : 0;
      hi_col = (base_col + span < lifeg_pkg::GRID_COLS) ? base_col + span
                                                         : lifeg_pkg::GRID_COLS - 1;
      hi_row = (base_row + span < lifeg_pkg::GRID_ROWS) ? base_row + span
                                                         : lifeg_pkg::GRID_ROWS - 1;
      repeat ($urandom_range(20, 6))
         send_request(lifeg_pkg::CMD_WRITE,
                      lifeg_pkg::CCOL_W'(base_col + $urandom_range(span - 1)),
                      lifeg_pkg::CROW_W'(base_row + $urandom_range(span - 1)),
                      $urandom_range(99) < 55);
      repeat ($urandom_range(3, 1)) begin
         // The address fields of a generation request carry random junk.
         send_request(lifeg_pkg::CMD_STEP, lifeg_pkg::CCOL_W'($urandom_range(63)),
                      lifeg_pkg::CROW_W'($urandom_range(31)), 1'($urandom_range(1)));
         repeat ($urandom_range(6, 2))
            send_request(lifeg_pkg::CMD_READ,
                         lifeg_pkg::CCOL_W'($urandom_range(hi_col, lo_col)),
                         lifeg_pkg::CROW_W'($urandom_range(hi_row, lo_row)),
                         1'($urandom_range(1)));
      end
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(4, 1))
            send_request(lifeg_pkg::CMD_W'($urandom_range(3)),
                         lifeg_pkg::CCOL_W'($urandom_range(63)),
                         lifeg_pkg::CROW_W'($urandom_range(31)), 1'($urandom_range(1)));
   endtask

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      rx_idle_pct <= 76;
      tx_idle_pct  = 11;
      sent_total   = 0;
      write_count  = 0;
      read_count   = 0;
      step_count   = 0;
      unused_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct  = 11;
               rx_idle_pct <= 76;
            end
            1: begin
               tx_idle_pct  = 76;
               rx_idle_pct <= 11;
            end
            default: begin
               tx_idle_pct  = 0;
               rx_idle_pct <= 0;
            end
         endcase
         if (phase == 0) begin
            // Fresh grid reads dead at both far corners.
            send_request(lifeg_pkg::CMD_READ, 0, 0, 1'b1);
            send_request(lifeg_pkg::CMD_READ, 63, 31, 1'b1);
            send_request(lifeg_pkg::CMD_WRITE, 0, 0, 1'b1);
            send_request(lifeg_pkg::CMD_WRITE, 63, 0, 1'b1);
            send_request(lifeg_pkg::CMD_WRITE, 0, 31, 1'b1);
            send_request(lifeg_pkg::CMD_WRITE, 63, 31, 1'b1);
            send_request(lifeg_pkg::CMD_READ, 0, 0, 1'b0);
            send_request(lifeg_pkg::CMD_READ, 63, 0, 1'b0);
            send_request(lifeg_pkg::CMD_READ, 0, 31, 1'b0);
            send_request(lifeg_pkg::CMD_READ, 63, 31, 1'b0);
            send_request(lifeg_pkg::CMD_WRITE, 0, 0, 1'b0);
            send_request(lifeg_pkg::CMD_READ, 0, 0, 1'b1);
            // The unused command must leave the grid alone.
            send_request(CMD_UNUSED, 63, 31, 1'b1);
            send_request(lifeg_pkg::CMD_READ, 63, 31, 1'b0);
            // A blinker: its center survives on two neighbors, the ends die.
            send_request(lifeg_pkg::CMD_WRITE, 30, 15, 1'b1);
            send_request(lifeg_pkg::CMD_WRITE, 31, 15, 1'b1);
            send_request(lifeg_pkg::CMD_WRITE, 32, 15, 1'b1);
            send_request(lifeg_pkg::CMD_STEP, 0, 0, 1'b0);
            send_request(lifeg_pkg::CMD_READ, 31, 14, 1'b0);
            send_request(lifeg_pkg::CMD_READ, 31, 16, 1'b0);
            send_request(lifeg_pkg::CMD_READ, 30, 15, 1'b0);
            send_request(lifeg_pkg::CMD_READ, 63, 31, 1'b0);
            send_request(lifeg_pkg::CMD_STEP, 63, 31, 1'b1);
            send_request(lifeg_pkg::CMD_READ, 30, 15, 1'b0);
            send_request(lifeg_pkg::CMD_READ, 31, 14, 1'b0);
         end
         while (sent_total < (ITEM_TARGET * (phase + 1)) / 3)
            run_round();
      end
      req_tvalid <= 1'b0;

      do
         @(posedge clock);
      while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d writes, %0d reads, %0d generations, %0d unused",
               sent_total, write_count, read_count, step_count, unused_count);
      $display("Checked %0d responses across three handshake pressure phases",
               checked_count);
      if (fail_count == 0 && pending_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
sv/lifeg_pkg.sv
sv/lifeg_datapath.sv
sv/lifeg_ctrl.sv
sv/life_cellular_automaton_grid_core.sv
tb/life_grid_checker.sv
tb/tb.sv
